>>> rtl/pncorr_pkg.sv
package pncorr_pkg;

  // Default geometry of the correlator.
  localparam int unsigned CodeLenDef = 255;
  localparam int unsigned DataLenDef = 512;

  // Largest code the configuration registers can hold.
  localparam int unsigned CodeMax = 255;

  // Field widths fixed by the interface.
  localparam int unsigned CntW   = 10;
  localparam int unsigned ShiftW = 9;
  localparam int unsigned CorrW  = 9;
  localparam int unsigned BestW  = 10;
  localparam int unsigned MmW    = 8;
  localparam int unsigned GrpW   = 4;
  localparam int unsigned PartW  = 7;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CODE_WORD_0 = 2'd0,
    REG_CODE_WORD_1 = 2'd1,
    REG_CODE_WORD_2 = 2'd2,
    REG_CODE_WORD_3 = 2'd3
  } cfg_reg_e;

  // Queue between front and back.
  localparam int unsigned FifoDepth = 4;

  // One classified chip, as handed from the front to the back.
  typedef struct packed {
    logic              full;
    logic [ShiftW-1:0] shift;
    logic [CntW-1:0]   cnt;
    logic [MmW-1:0]    mm;
    logic              last;
  } desc_t;

endpackage

>>> rtl/pncorr_if.sv
interface pncorr_in_if;
  logic valid;
  logic ready;
  logic chip;
  logic record_end;

  modport source (output valid, output chip, output record_end, input ready);
  modport sink   (input valid, input chip, input record_end, output ready);
endinterface

interface pncorr_out_if;
  logic              valid;
  logic              ready;
  logic              window_full;
  logic [8:0]        shift_index;
  logic signed [8:0] correlation;
  logic signed [9:0] max_shift;
  logic signed [9:0] max_correlation;
  logic              record_done;

  modport source (output valid, output window_full, output shift_index, output correlation,
                  output max_shift, output max_correlation, output record_done,
                  input ready);
  modport sink   (input valid, input window_full, input shift_index, input correlation,
                  input max_shift, input max_correlation, input record_done,
                  output ready);
endinterface

interface pncorr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/pncorr_front.sv
module pncorr_front import pncorr_pkg::*; #(
  parameter int unsigned CODE_LEN = CodeLenDef,
  parameter int unsigned DATA_LEN = DataLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CodeMax-1:0] code_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_chip_i,
  input  logic               in_last_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output desc_t              push_data_o
);

  localparam int unsigned NGrp  = (CODE_LEN + 7) / 8;
  localparam int unsigned NPart = (NGrp + 7) / 8;

  logic [CODE_LEN-1:0] win_q, win_d, win_new;
  logic [CntW-1:0]     cnt_q, cnt_d, cnt_inc;
  logic                take, adv, live;
  logic [NGrp*8-1:0]   mism;

  logic [GrpW-1:0]     grp_d [NGrp];
  logic [GrpW-1:0]     grp_q [NGrp];
  logic [PartW-1:0]    part_d [NPart];
  logic [PartW-1:0]    part_q [NPart];
  logic [MmW-1:0]      mm_d;

  desc_t d1_d, d1_q, d2_q, d3_d, d3_q;
  logic  v1_q, v2_q, v3_q;

  // The pipeline moves as a whole when its last stage is empty or drains.
  assign adv        = !v3_q || push_ready_i;
  assign in_ready_o = adv;
  assign take       = in_valid_i && adv;

  // Chips past the record limit are dropped; the count saturates.
  assign live    = (cnt_q != CntW'(DATA_LEN));
  assign cnt_inc = cnt_q + CntW'(1);
  assign win_new = {in_chip_i, win_q[CODE_LEN-1:1]};

  always_comb begin
    win_d = win_q;
    cnt_d = cnt_q;
    if (take) begin
      if (in_last_i) begin
        win_d = '0;
        cnt_d = '0;
      end else if (live) begin
        win_d = win_new;
        cnt_d = cnt_inc;
      end
    end
  end

  // Classify the chip and count mismatches in groups of eight.
  always_comb begin
    logic [GrpW-1:0] acc;
    mism = '0;
    mism[CODE_LEN-1:0] = (live ? win_new : win_q) ^ code_i[CODE_LEN-1:0];
    for (int g = 0; g < NGrp; g++) begin
      acc = '0;
      for (int b = 0; b < 8; b++) begin
        acc = acc + GrpW'(mism[g*8+b]);
      end
      grp_d[g] = acc;
    end
    d1_d.full  = live && (cnt_inc >= CntW'(CODE_LEN));
    d1_d.shift = ShiftW'(cnt_inc - CntW'(CODE_LEN));
    d1_d.cnt   = live ? cnt_inc : cnt_q;
    d1_d.mm    = '0;
    d1_d.last  = in_last_i;
  end

  // Second level of the count: sums over eight groups.
  always_comb begin
    logic [PartW-1:0] acc;
    for (int p = 0; p < NPart; p++) begin
      acc = '0;
      for (int k = 0; k < 8; k++) begin
        if (p * 8 + k < NGrp) begin
          acc = acc + PartW'(grp_q[p*8+k]);
        end
      end
      part_d[p] = acc;
    end
  end

  // Final level of the count.
  always_comb begin
    mm_d = '0;
    for (int p = 0; p < NPart; p++) begin
      mm_d = mm_d + MmW'(part_q[p]);
    end
  end

  // The last stage joins the mismatch count to its descriptor.
  always_comb begin
    d3_d    = d2_q;
    d3_d.mm = mm_d;
  end

  // Record state and stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      cnt_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      win_q <= win_d;
      cnt_q <= cnt_d;
      if (adv) begin
        v1_q <= in_valid_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_q   <= d1_d;
      grp_q  <= grp_d;
      d2_q   <= d1_q;
      part_q <= part_d;
      d3_q   <= d3_d;
    end
  end

  assign push_valid_o = v3_q;
  assign push_data_o  = d3_q;

endmodule

>>> rtl/pncorr_fifo.sv
module pncorr_fifo import pncorr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  desc_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output desc_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);

  desc_t           mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   fill_q;
  logic            push, pop;

  assign push_ready_o = (fill_q != (PtrW+1)'(FifoDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + (PtrW+1)'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - (PtrW+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/pncorr_back.sv
module pncorr_back import pncorr_pkg::*; #(
  parameter int unsigned CODE_LEN = CodeLenDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    head_valid_i,
  output logic                    head_ready_o,
  input  desc_t                   head_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    out_full_o,
  output logic [ShiftW-1:0]       out_shift_o,
  output logic signed [CorrW-1:0] out_corr_o,
  output logic signed [BestW-1:0] out_bshift_o,
  output logic signed [BestW-1:0] out_bcorr_o,
  output logic                    out_done_o
);

  logic                    any_q, any_d, any_new;
  logic signed [BestW-1:0] top_q, top_d, top_new;
  logic signed [BestW-1:0] tsh_q, tsh_d, tsh_new;
  logic signed [BestW-1:0] corr10, bshift, bcorr;
  logic                    take, better;

  logic                    oval_q;
  logic                    ofull_q, odone_q;
  logic [ShiftW-1:0]       oshift_q;
  logic signed [CorrW-1:0] ocorr_q;
  logic signed [BestW-1:0] obshift_q, obcorr_q;

  // The output register takes a beat when it is empty or being drained.
  assign head_ready_o = !oval_q || out_ready_i;
  assign take         = head_valid_i && head_ready_o;

  // Correlation is the code length less twice the mismatch count.
  assign corr10 = $signed(BestW'(CODE_LEN) - {1'b0, head_i.mm, 1'b0});
  assign better = head_i.full && (!any_q || (corr10 > top_q));

  always_comb begin
    any_new = any_q || head_i.full;
    top_new = better ? corr10 : top_q;
    tsh_new = better ? $signed({1'b0, head_i.shift}) : tsh_q;
    if (any_new) begin
      bshift = tsh_new;
      bcorr  = top_new;
    end else begin
      bshift = '1;
      bcorr  = $signed(BestW'(0) - head_i.cnt);
    end
    any_d = any_q;
    top_d = top_q;
    tsh_d = tsh_q;
    if (take) begin
      if (head_i.last) begin
        any_d = 1'b0;
        top_d = '0;
        tsh_d = '1;
      end else begin
        any_d = any_new;
        top_d = top_new;
        tsh_d = tsh_new;
      end
    end
  end

  // Best-so-far tracker and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q  <= 1'b0;
      top_q  <= '0;
      tsh_q  <= '1;
      oval_q <= 1'b0;
    end else begin
      any_q <= any_d;
      top_q <= top_d;
      tsh_q <= tsh_d;
      if (head_ready_o) begin
        oval_q <= head_valid_i;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      ofull_q   <= head_i.full;
      oshift_q  <= head_i.full ? head_i.shift : '0;
      ocorr_q   <= head_i.full ? corr10[CorrW-1:0] : '0;
      obshift_q <= bshift;
      obcorr_q  <= bcorr;
      odone_q   <= head_i.last;
    end
  end

  assign out_valid_o  = oval_q;
  assign out_full_o   = ofull_q;
  assign out_shift_o  = oshift_q;
  assign out_corr_o   = ocorr_q;
  assign out_bshift_o = obshift_q;
  assign out_bcorr_o  = obcorr_q;
  assign out_done_o   = odone_q;

endmodule

>>> rtl/pn_code_sliding_correlator.sv
// Throughput: one chip per cycle unless back-pressure stalls the front; the three
// register levels of the mismatch count tree are fully pipelined, and a four-entry
// queue lets front and back stall apart.
// Reset (rst_ni low, asynchronous): code registers, chip window, chip count and the
// best-so-far tracker clear; the best shift reads as minus one.
module pn_code_sliding_correlator import pncorr_pkg::*; #(
  parameter int unsigned CODE_LEN = CodeLenDef,
  parameter int unsigned DATA_LEN = DataLenDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pncorr_cfg_if.sink   cfg_i,
  pncorr_in_if.sink    in_i,
  pncorr_out_if.source out_o
);

  logic [CodeMax-1:0] code_q;
  logic               push_valid, push_ready, head_valid, head_ready;
  desc_t              push_data, head_data;

  // Code registers; writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_CODE_WORD_0: code_q[63:0]    <= cfg_i.data;
        REG_CODE_WORD_1: code_q[127:64]  <= cfg_i.data;
        REG_CODE_WORD_2: code_q[191:128] <= cfg_i.data;
        REG_CODE_WORD_3: code_q[254:192] <= cfg_i.data[62:0];
        default: code_q <= code_q;
      endcase
    end
  end

  // Front: window, chip count and mismatch count tree.
  pncorr_front #(
    .CODE_LEN(CODE_LEN),
    .DATA_LEN(DATA_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .code_i      (code_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_chip_i   (in_i.chip),
    .in_last_i   (in_i.record_end),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  // Queue between the two halves.
  pncorr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (head_valid),
    .pop_ready_i (head_ready),
    .pop_data_o  (head_data)
  );

  // Back: best-so-far tracking and the output register.
  pncorr_back #(
    .CODE_LEN(CODE_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_ready_o(head_ready),
    .head_i      (head_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_full_o  (out_o.window_full),
    .out_shift_o (out_o.shift_index),
    .out_corr_o  (out_o.correlation),
    .out_bshift_o(out_o.max_shift),
    .out_bcorr_o (out_o.max_correlation),
    .out_done_o  (out_o.record_done)
  );

endmodule

>>> dv/pn_code_sliding_correlator_test.sv
`timescale 1ns / 1ps

module pn_code_sliding_correlator_test;
  import pncorr_pkg::*;

  localparam int CodeLen      = CodeLenDef;
  localparam int DataLen      = DataLenDef;
  localparam int ClkPeriod    = 10;
  localparam int SettleCycles = 12;
  localparam int ItemsPerPhase = 315;
  localparam int unsigned LimitCycles = 200_000;

  // One result beat as the block reports it.
  typedef struct packed {
    logic                     window_full;
    logic [ShiftW-1:0]        shift_index;
    logic signed [CorrW-1:0]  correlation;
    logic signed [BestW-1:0]  max_shift;
    logic signed [BestW-1:0]  max_correlation;
    logic                     record_done;
  } corr_result_t;

  typedef enum logic [1:0] {ROW_CHIPS, ROW_CODE} row_kind_e;
  typedef enum logic [1:0] {FILL_ZERO, FILL_ONE, FILL_RAND} fill_e;

  // A directed row is either a run of chips (all zero, all one or random) or a code load.
  typedef struct {
    row_kind_e    kind;
    logic [63:0]  code;
    int           count;
    fill_e        fill;
    bit           end_last;
    bit           typed;
    corr_result_t want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  pncorr_cfg_if cfg_bus ();
  pncorr_in_if  chip_bus ();
  pncorr_out_if result_bus ();

  pn_code_sliding_correlator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (chip_bus),
    .out_o  (result_bus)
  );

  // Shadow of the code registers and of the record being correlated.
  logic [63:0]        code_reg [4];
  logic [CodeLen-1:0] window_bits;
  int                 chips_in_record;
  int                 peak_corr;
  int                 peak_shift;
  bit                 window_seen;

  corr_result_t corr_due [$];
  int unsigned  mismatches;
  int unsigned  cycle_count;
  int unsigned  send_gap_pct;
  int unsigned  recv_stall_pct;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic void forget_record();
    window_bits     = '0;
    chips_in_record = 0;
    peak_corr       = 0;
    peak_shift      = -1;
    window_seen     = 1'b0;
  endfunction

  // Works out the beat for one chip and advances the shadow record.
  function automatic corr_result_t predict_correlation(input logic chip, input logic last);
    corr_result_t       r;
    logic [CodeLen-1:0] code_bits;
    int                 corr;
    r = '0;
    code_bits = {code_reg[3][62:0], code_reg[2], code_reg[1], code_reg[0]};
    if (chips_in_record < DataLen) begin
      window_bits = {chip, window_bits[CodeLen-1:1]};
      chips_in_record++;
      if (chips_in_record >= CodeLen) begin
        corr = CodeLen - 2 * int'($countones(window_bits ^ code_bits));
        r.window_full = 1'b1;
        r.shift_index = ShiftW'(chips_in_record - CodeLen);
        r.correlation = CorrW'(corr);
        // Only a strictly higher peak moves the best shift, so ties keep the earliest.
        if (!window_seen || corr > peak_corr) begin
          peak_corr   = corr;
          peak_shift  = chips_in_record - CodeLen;
          window_seen = 1'b1;
        end
      end
    end
    r.max_shift       = window_seen ? BestW'(peak_shift) : BestW'(-1);
    r.max_correlation = window_seen ? BestW'(peak_corr) : BestW'(-chips_in_record);
    r.record_done     = last;
    if (last) forget_record();
    return r;
  endfunction

  function automatic corr_result_t outcome(input bit full, input int shift, input int corr,
                                           input int bshift, input int bcorr, input bit done);
    corr_result_t r;
    r.window_full     = full;
    r.shift_index     = ShiftW'(shift);
    r.correlation     = CorrW'(corr);
    r.max_shift       = BestW'(bshift);
    r.max_correlation = BestW'(bcorr);
    r.record_done     = done;
    return r;
  endfunction

  function automatic plan_row_t chip_row(input int count, input fill_e fill, input bit end_last,
                                         input bit typed, input corr_result_t want);
    plan_row_t p;
    p.kind     = ROW_CHIPS;
    p.code     = '0;
    p.count    = count;
    p.fill     = fill;
    p.end_last = end_last;
    p.typed    = typed;
    p.want     = want;
    return p;
  endfunction

  function automatic plan_row_t code_row(input logic [63:0] code);
    plan_row_t p;
    p = chip_row(0, FILL_ZERO, 1'b0, 1'b0, '0);
    p.kind = ROW_CODE;
    p.code = code;
    return p;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Offers one chip beat, with random gaps, and logs its expectation on acceptance.
  task automatic send_chip(input logic chip, input logic last, input bit typed,
                           input corr_result_t want);
    corr_result_t predicted;
    predicted = predict_correlation(chip, last);
    while ($urandom_range(99) < send_gap_pct) begin
      chip_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    chip_bus.valid      <= 1'b1;
    chip_bus.chip       <= chip;
    chip_bus.record_end <= last;
    do @(posedge clk_i); while (!chip_bus.ready);
    corr_due.push_back(typed ? want : predicted);
  endtask

  // Holds the chip stream off until every beat is home and the pipeline is quiet.
  task automatic wait_idle();
    chip_bus.valid <= 1'b0;
    while (corr_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all four code words; words[64*i +: 64] goes to register i.
  task automatic load_code(input logic [255:0] words);
    cfg_reg_e reg_idx;
    for (int i = 0; i < 4; i++) begin
      reg_idx = cfg_reg_e'(i);
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= reg_idx;
      cfg_bus.data  <= words[64*i +: 64];
      do @(posedge clk_i); while (!cfg_bus.ready);
      code_reg[reg_idx] = words[64*i +: 64];
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Random records: mostly the code buried at some offset with a few chip errors,
  // the rest plain noise, with lengths from short to past the data limit, cut
  // short where the phase's budget of chips runs out.
  task automatic run_records(input int target);
    logic [CodeLen-1:0] code_bits;
    int  sent;
    int  len;
    int  pick;
    int  offset;
    int  flip_pct;
    bit  embed;
    logic chip;
    sent = 0;
    while (sent < target) begin
      code_bits = {code_reg[3][62:0], code_reg[2], code_reg[1], code_reg[0]};
      pick = $urandom_range(99);
      if (pick < 25) len = $urandom_range(CodeLen - 1, 1);
      else if (pick < 80) len = $urandom_range(420, CodeLen);
      else len = $urandom_range(DataLen + 28, DataLen - 12);
      if (len > target - sent) len = target - sent;
      embed    = $urandom_range(99) < 65;
      flip_pct = $urandom_range(15);
      offset   = (len > CodeLen) ? $urandom_range(len - CodeLen) : 0;
      for (int i = 0; i < len; i++) begin
        if (embed && i >= offset && i < offset + CodeLen)
          chip = code_bits[i - offset] ^ ($urandom_range(99) < flip_pct);
        else
          chip = 1'($urandom_range(1));
        send_chip(chip, i == len - 1, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result side: random back-pressure and in-order comparison.
  always @(posedge clk_i) begin
    corr_result_t want;
    result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (corr_due.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
      end else begin
        want = corr_due.pop_front();
        check_field("window_full", want.window_full, result_bus.window_full);
        check_field("shift_index", want.shift_index, result_bus.shift_index);
        check_field("correlation", want.correlation, result_bus.correlation);
        check_field("max_shift", want.max_shift, result_bus.max_shift);
        check_field("max_correlation", want.max_correlation, result_bus.max_correlation);
        check_field("record_done", want.record_done, result_bus.record_done);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [$];
    logic      chip;
    bit        last_one;

    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_CODE_WORD_0;
    cfg_bus.data        = '0;
    chip_bus.valid      = 1'b0;
    chip_bus.chip       = 1'b0;
    chip_bus.record_end = 1'b0;
    result_bus.ready    = 1'b0;
    mismatches          = 0;
    cycle_count         = 0;
    send_gap_pct        = 29;
    recv_stall_pct      = 47;
    for (int i = 0; i < 4; i++) code_reg[i] = '0;
    forget_record();

    // Directed runs; the code is all zeros until the first all-ones load.
    plan.push_back(code_row(64'h0));
    plan.push_back(chip_row(1, FILL_ZERO, 1'b0, 1'b1, outcome(0, 0, 0, -1, -1, 0)));
    plan.push_back(chip_row(1, FILL_ONE, 1'b1, 1'b1, outcome(0, 0, 0, -1, -2, 1)));
    plan.push_back(chip_row(254, FILL_ZERO, 1'b0, 1'b1, outcome(0, 0, 0, -1, -254, 0)));
    plan.push_back(chip_row(1, FILL_ZERO, 1'b0, 1'b1, outcome(1, 0, 255, 0, 255, 0)));
    plan.push_back(chip_row(1, FILL_ONE, 1'b0, 1'b1, outcome(1, 1, 253, 0, 255, 0)));
    plan.push_back(chip_row(254, FILL_ONE, 1'b0, 1'b1, outcome(1, 255, -255, 0, 255, 0)));
    plan.push_back(chip_row(2, FILL_ZERO, 1'b0, 1'b1, outcome(1, 257, -251, 0, 255, 0)));
    // Past the data limit: chips are dropped, then the end flag still closes the record.
    plan.push_back(chip_row(1, FILL_ONE, 1'b0, 1'b1, outcome(0, 0, 0, 0, 255, 0)));
    plan.push_back(chip_row(1, FILL_ZERO, 1'b1, 1'b1, outcome(0, 0, 0, 0, 255, 1)));
    plan.push_back(chip_row(3, FILL_ZERO, 1'b1, 1'b1, outcome(0, 0, 0, -1, -3, 1)));
    plan.push_back(chip_row(20, FILL_RAND, 1'b1, 1'b0, '0));
    plan.push_back(code_row(64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(chip_row(255, FILL_ONE, 1'b0, 1'b1, outcome(1, 0, 255, 0, 255, 0)));
    // An equal peak later on must not move the best shift.
    plan.push_back(chip_row(1, FILL_ONE, 1'b0, 1'b1, outcome(1, 1, 255, 0, 255, 0)));
    plan.push_back(chip_row(1, FILL_ZERO, 1'b1, 1'b1, outcome(1, 2, 253, 0, 255, 1)));
    plan.push_back(chip_row(10, FILL_RAND, 1'b1, 1'b0, '0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CODE) begin
        wait_idle();
        load_code({4{plan[r].code}});
      end else begin
        for (int k = 0; k < plan[r].count; k++) begin
          case (plan[r].fill)
            FILL_ZERO: chip = 1'b0;
            FILL_ONE:  chip = 1'b1;
            default:   chip = 1'($urandom_range(1));
          endcase
          last_one = (k == plan[r].count - 1);
          send_chip(chip, plan[r].end_last && last_one, plan[r].typed && last_one,
                    plan[r].want);
        end
      end
    end

    // Random phases, each under a fresh code and its own idling pattern.
    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          send_gap_pct   = 29;
          recv_stall_pct = 47;
        end
        1: begin
          send_gap_pct   = 47;
          recv_stall_pct = 29;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      load_code({$urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom()});
      run_records(ItemsPerPhase);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
